/* sv/scpa_pkg.sv */
package scpa_pkg;

   localparam int ADDR_W      = 21;
   localparam int CLASS_W     = 4;
   localparam int STATUS_W    = 2;
   localparam int BLOCKS_W    = 5;
   localparam int REQ_BYTES_W = 16;
   localparam int TAG_W       = CLASS_W + 1;
   localparam int HDR_BYTES   = 2;
   localparam int GRAN_BYTES  = 16;
   localparam int REQ_TDATA_W = 40;
   localparam int RSP_TDATA_W = 32;

   localparam logic REQ_ALLOC = 1'b0;
   localparam logic REQ_FREE  = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_TOO_LARGE = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_EXHAUSTED = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_BAD_MARK  = 2'd3;

   typedef struct packed {
      logic clear;
      logic load;
      logic lookup;
      logic exec;
      logic carve;
      logic place;
   } scpa_cmd_type;

   typedef struct packed {
      logic clear_last;
      logic out_free;
      logic need_carve;
      logic carve_end;
   } scpa_sts_type;

endpackage

/* sv/scpa_ctrl.sv */
module scpa_ctrl import scpa_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  scpa_sts_type sts,
   output scpa_cmd_type cmd
);

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_LOOK  = 3'd2;
   localparam logic [2:0] ST_EXEC  = 3'd3;
   localparam logic [2:0] ST_CARVE = 3'd4;
   localparam logic [2:0] ST_PLACE = 3'd5;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear = 1'b1;
            if (sts.clear_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_LOOK;
            end
         end
         ST_LOOK: begin
            cmd.lookup = 1'b1;
            state_in = ST_EXEC;
         end
         ST_EXEC: begin
            // The result register must be free before anything is committed.
            if (sts.out_free) begin
               cmd.exec = 1'b1;
               state_in = sts.need_carve ? ST_CARVE : ST_IDLE;
            end
         end
         ST_CARVE: begin
            cmd.carve = 1'b1;
            if (sts.carve_end) state_in = ST_PLACE;
         end
         ST_PLACE: begin
            if (sts.out_free) begin
               cmd.place = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_CLEAR;
      else state_ff <= state_in;
   end

endmodule

/* sv/scpa_datapath.sv */
module scpa_datapath import scpa_pkg::*; #(
   parameter int NUM_CLASSES = 12,
   parameter int BLOCK_BYTES = 131072,
   parameter int POOL_BLOCKS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  scpa_cmd_type           cmd,
   output scpa_sts_type           sts,
   input  logic                   req_kind,
   input  logic [REQ_BYTES_W-1:0] req_bytes,
   input  logic [ADDR_W-1:0]      req_addr,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [ADDR_W-1:0]      rsp_address,
   output logic [CLASS_W-1:0]     rsp_class,
   output logic [STATUS_W-1:0]    rsp_status,
   output logic [BLOCKS_W-1:0]    rsp_blocks
);

   localparam int POOL_BYTES = POOL_BLOCKS * BLOCK_BYTES;
   localparam int GRANULES   = POOL_BYTES / GRAN_BYTES;
   localparam int GW         = $clog2(GRANULES);
   localparam int PW         = GW + 4;
   localparam int XW         = (PW > ADDR_W) ? PW : ADDR_W;
   localparam int OW         = $clog2(BLOCK_BYTES) + 2;
   localparam int CBW        = $clog2(POOL_BLOCKS + 1);
   localparam int HIW        = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
   localparam int NEED_W     = REQ_BYTES_W + 1;

   function automatic logic [OW-1:0] class_size(input logic [CLASS_W-1:0] c);
      return OW'(GRAN_BYTES) << c;
   endfunction

   // Memories: header tags and free-list links, one entry per granule.
   logic [TAG_W-1:0] tag_mem [GRANULES];
   logic [GW-1:0]    link_mem [GRANULES];
   logic [TAG_W-1:0] tag_rd_ff;
   logic [GW-1:0]    link_rd_ff;

   logic [GW-1:0]          head_gran_ff [NUM_CLASSES];
   logic [NUM_CLASSES-1:0] head_vld_ff;

   logic                kind_ff, big_ff, fchk_ff;
   logic [CLASS_W-1:0]  cls_ff, cc_ff, cc_in;
   logic [ADDR_W-1:0]   faddr_ff;
   logic [GW-1:0]       fgran_ff, clr_ff;
   logic [CBW-1:0]      cb_ff, cb_in;
   logic [PW-1:0]       base_ff, base_in;
   logic [OW-1:0]       bump_ff, bump_in;

   logic                rsp_valid_ff;
   logic [ADDR_W-1:0]   rsp_address_ff, rsp_address_in;
   logic [CLASS_W-1:0]  rsp_class_ff, rsp_class_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [BLOCKS_W-1:0] rsp_blocks_ff;
   logic                rsp_load;

   // Request decode at accept time.
   logic [NEED_W-1:0]   need;
   logic [CLASS_W-1:0]  sel_cls;
   logic                sel_big;
   logic [ADDR_W-1:0]   fa_m2;
   logic [XW-1:0]       fx;
   logic                fchk;

   always_comb begin
      need = NEED_W'(req_bytes) + NEED_W'(HDR_BYTES);
      sel_cls = CLASS_W'(NUM_CLASSES - 1);
      sel_big = 1'b1;
      for (int i = NUM_CLASSES - 1; i >= 0; i--) begin
         if ((NEED_W'(GRAN_BYTES) << i) >= need) begin
            sel_cls = CLASS_W'(i);
            sel_big = 1'b0;
         end
      end
      fa_m2 = req_addr - ADDR_W'(HDR_BYTES);
      fx = XW'(fa_m2) >> 4;
      fchk = (req_addr >= ADDR_W'(HDR_BYTES)) && (fa_m2[3:0] == 4'd0) &&
             (fx < XW'(GRANULES));
   end

   // Head table, read at a single selected class.
   logic [HIW-1:0]     hidx;
   logic [GW-1:0]      cur_head;
   logic               cur_hv;
   logic [CLASS_W-1:0] tcls;
   logic               free_ok, is_free;

   assign is_free = (kind_ff == REQ_FREE);
   assign tcls = tag_rd_ff[CLASS_W-1:0];
   assign free_ok = fchk_ff && tag_rd_ff[TAG_W-1] &&
                    (tcls < CLASS_W'(NUM_CLASSES));

   always_comb begin
      if (cmd.carve) hidx = cc_ff[HIW-1:0];
      else if (is_free) hidx = tcls[HIW-1:0];
      else hidx = cls_ff[HIW-1:0];
   end

   assign cur_head = head_gran_ff[hidx];
   assign cur_hv = head_vld_ff[hidx];

   // Bump placement and carving arithmetic.
   logic [OW-1:0] sz, bump_sum, csz, carve_sum;
   logic          need_new, exhausted, carve_fit, do_bump, do_place;
   logic [PW-1:0] new_base, place_start, carve_start;
   logic [GW-1:0] place_gran, carve_gran;

   assign sz = class_size(cls_ff);
   assign bump_sum = bump_ff + sz;
   assign need_new = (cb_ff == '0) || (bump_sum > OW'(BLOCK_BYTES));
   assign exhausted = need_new && (cb_ff >= CBW'(POOL_BLOCKS));
   assign new_base = (cb_ff == '0) ? '0 : base_ff + PW'(BLOCK_BYTES);
   assign place_start = need_new ? new_base : base_ff + PW'(bump_ff);
   assign place_gran = place_start[PW-1:4];
   assign csz = class_size(cc_ff);
   assign carve_sum = bump_ff + csz;
   assign carve_fit = carve_sum <= OW'(BLOCK_BYTES);
   assign carve_start = base_ff + PW'(bump_ff);
   assign carve_gran = carve_start[PW-1:4];

   assign do_bump = !is_free && !big_ff && !cur_hv;
   assign do_place = cmd.place ||
                     (cmd.exec && do_bump && !exhausted && !(need_new && cb_ff != '0));

   assign sts.clear_last = (clr_ff == GW'(GRANULES - 1));
   assign sts.out_free = !rsp_valid_ff || rsp_ready;
   assign sts.need_carve = do_bump && need_new && (cb_ff != '0) && !exhausted;
   assign sts.carve_end = !carve_fit && (cc_ff == '0);

   logic               tag_we, link_we, head_we, head_wv;
   logic [GW-1:0]      tag_wa, link_wa, link_wd, head_wg;
   logic [TAG_W-1:0]   tag_wd;
   logic [HIW-1:0]     head_wi;

   always_comb begin
      tag_we = 1'b0;  tag_wa = '0;  tag_wd = '0;
      link_we = 1'b0; link_wa = '0; link_wd = '0;
      head_we = 1'b0; head_wi = hidx; head_wg = '0; head_wv = 1'b0;
      cb_in = cb_ff;  base_in = base_ff; bump_in = bump_ff; cc_in = cc_ff;
      rsp_load = 1'b0;
      rsp_address_in = '0;
      rsp_class_in = '0;
      rsp_status_in = STATUS_OK;

      if (cmd.clear) begin
         tag_we = 1'b1;
         tag_wa = clr_ff;
      end

      if (cmd.exec) begin
         if (is_free) begin
            rsp_load = 1'b1;
            if (free_ok) begin
               tag_we = 1'b1;
               tag_wa = fgran_ff;
               link_we = 1'b1;
               link_wa = fgran_ff;
               link_wd = cur_hv ? cur_head : fgran_ff;
               head_we = 1'b1;
               head_wg = fgran_ff;
               head_wv = 1'b1;
               rsp_address_in = faddr_ff;
               rsp_class_in = tcls;
            end else begin
               rsp_status_in = STATUS_BAD_MARK;
            end
         end else if (big_ff) begin
            rsp_load = 1'b1;
            rsp_status_in = STATUS_TOO_LARGE;
         end else if (cur_hv) begin
            // Pop: a piece that links to itself is the last one on its list.
            rsp_load = 1'b1;
            head_we = 1'b1;
            head_wv = (link_rd_ff != cur_head);
            head_wg = link_rd_ff;
            tag_we = 1'b1;
            tag_wa = cur_head;
            tag_wd = {1'b1, cls_ff};
            rsp_address_in = ADDR_W'(XW'({cur_head, 4'd0}) + XW'(HDR_BYTES));
            rsp_class_in = cls_ff;
         end else if (exhausted) begin
            rsp_load = 1'b1;
            rsp_status_in = STATUS_EXHAUSTED;
         end else if (need_new && cb_ff != '0) begin
            cc_in = CLASS_W'(NUM_CLASSES - 1);
         end
      end

      if (cmd.carve) begin
         if (carve_fit) begin
            link_we = 1'b1;
            link_wa = carve_gran;
            link_wd = cur_hv ? cur_head : carve_gran;
            head_we = 1'b1;
            head_wg = carve_gran;
            head_wv = 1'b1;
            bump_in = carve_sum;
         end else if (cc_ff != '0) begin
            cc_in = cc_ff - 1'b1;
         end
      end

      if (do_place) begin
         rsp_load = 1'b1;
         if (need_new) begin
            cb_in = cb_ff + 1'b1;
            base_in = new_base;
            bump_in = sz;
         end else begin
            bump_in = bump_sum;
         end
         tag_we = 1'b1;
         tag_wa = place_gran;
         tag_wd = {1'b1, cls_ff};
         rsp_address_in = ADDR_W'(XW'(place_start) + XW'(HDR_BYTES));
         rsp_class_in = cls_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (tag_we) tag_mem[tag_wa] <= tag_wd;
      if (cmd.lookup) tag_rd_ff <= tag_mem[fgran_ff];
   end

   always_ff @(posedge clock) begin
      if (link_we) link_mem[link_wa] <= link_wd;
      if (cmd.lookup) link_rd_ff <= link_mem[cur_head];
   end

   always_ff @(posedge clock) begin
      if (head_we) head_gran_ff[head_wi] <= head_wg;
      if (cmd.load) begin
         kind_ff <= req_kind;
         cls_ff <= sel_cls;
         big_ff <= sel_big;
         faddr_ff <= req_addr;
         fgran_ff <= fx[GW-1:0];
         fchk_ff <= fchk;
      end
      cc_ff <= cc_in;
      base_ff <= base_in;
      if (rsp_load) begin
         rsp_address_ff <= rsp_address_in;
         rsp_class_ff <= rsp_class_in;
         rsp_status_ff <= rsp_status_in;
         rsp_blocks_ff <= BLOCKS_W'(cb_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_vld_ff <= '0;
         cb_ff <= '0;
         bump_ff <= '0;
         clr_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (head_we) head_vld_ff[head_wi] <= head_wv;
         cb_ff <= cb_in;
         bump_ff <= bump_in;
         if (cmd.clear) clr_ff <= clr_ff + 1'b1;
         if (rsp_load) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_address = rsp_address_ff;
   assign rsp_class = rsp_class_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_blocks = rsp_blocks_ff;

endmodule

/* sv/size_class_pool_allocator_core.sv */
// An accepted request passes the lookup and execute states; pops, frees and plain bump
// placements are answered from execute, while opening a new block after the first one
// also carves the rest of the old block, largest class first, before the place state.
// A new request is taken only after the last result is loaded into the result register.
// Reset is synchronous; afterwards the tag memory is cleared, one granule per cycle,
// over all POOL_BLOCKS*BLOCK_BYTES/16 granules (131072 by default) before req_tready rises.
module size_class_pool_allocator_core import scpa_pkg::*; #(
   parameter int NUM_CLASSES = 12,
   parameter int BLOCK_BYTES = 131072,
   parameter int POOL_BLOCKS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,  // request_bytes, count_in_stats, block_address
   input  logic                   req_tuser,  // req_type
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata   // address, size_class, status, blocks_in_use
);

   scpa_cmd_type        cmd;
   scpa_sts_type        sts;
   logic [ADDR_W-1:0]   address;
   logic [CLASS_W-1:0]  size_class;
   logic [STATUS_W-1:0] status;
   logic [BLOCKS_W-1:0] blocks_in_use;

   scpa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .sts       (sts),
      .cmd       (cmd)
   );

   scpa_datapath #(
      .NUM_CLASSES (NUM_CLASSES),
      .BLOCK_BYTES (BLOCK_BYTES),
      .POOL_BLOCKS (POOL_BLOCKS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .sts         (sts),
      .req_kind    (req_tuser),
      .req_bytes   (req_tdata[15:0]),
      .req_addr    (req_tdata[37:17]),
      .rsp_valid   (rsp_tvalid),
      .rsp_ready   (rsp_tready),
      .rsp_address (address),
      .rsp_class   (size_class),
      .rsp_status  (status),
      .rsp_blocks  (blocks_in_use)
   );

   assign rsp_tdata = {blocks_in_use, status, size_class, address};

endmodule

/* tb/sv/pool_alloc_checker.sv */
module pool_alloc_checker import scpa_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   input  logic                   req_tuser,
   input  logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  logic [RSP_TDATA_W-1:0] rsp_tdata,
   output int                     errors,
   output int                     pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int N_CLASSES  = 12;
   localparam int BLK_BYTES  = 131072;
   localparam int N_BLOCKS   = 16;
   localparam int N_GRANULES = N_BLOCKS * BLK_BYTES / GRAN_BYTES;

   typedef struct packed {
      logic [BLOCKS_W-1:0] blocks;
      logic [STATUS_W-1:0] status;
      logic [CLASS_W-1:0]  size_class;
      logic [ADDR_W-1:0]   address;
   } alloc_result_type;

   logic              head_ok [N_CLASSES];
   logic [16:0]       head_gran [N_CLASSES];
   logic [16:0]       next_gran [N_GRANULES];
   logic [TAG_W-1:0]  header_tag [N_GRANULES];
   int unsigned       bump;
   int unsigned       open_blocks;
   alloc_result_type  expected_results [$];

   assign pending = expected_results.size();

   function automatic int unsigned class_size(int unsigned c);
      return GRAN_BYTES << c;
   endfunction

   function automatic void push_free(int unsigned c, int unsigned g);
      next_gran[g] = head_ok[c] ? head_gran[c] : g[16:0];
      head_gran[c] = g[16:0];
      head_ok[c]   = 1'b1;
   endfunction

   function automatic int unsigned pop_free(int unsigned c);
      int unsigned g;
      g = 32'(head_gran[c]);
      if (next_gran[g] == g[16:0]) head_ok[c] = 1'b0;
      else head_gran[c] = next_gran[g];
      return g;
   endfunction

   // Spreads the rest of the current block over the free lists, largest class first.
   function automatic void carve_rest();
      int unsigned base;
      base = (open_blocks - 1) * BLK_BYTES;
      for (int c = N_CLASSES - 1; c >= 0; c--) begin
         while (bump + class_size(c) <= BLK_BYTES) begin
            push_free(c, (base + bump) >> 4);
            bump += class_size(c);
         end
      end
   endfunction

   function automatic alloc_result_type predict_alloc(logic kind, logic [15:0] nbytes,
                                                      logic [20:0] user_addr);
      alloc_result_type r;
      int unsigned      g, c, need, start;
      logic             fresh;
      r = '0;
      if (kind == REQ_FREE) begin
         r.status = STATUS_BAD_MARK;
         if (user_addr >= HDR_BYTES && ((user_addr - HDR_BYTES) & 15) == 0) begin
            g = (user_addr - HDR_BYTES) >> 4;
            if (g < N_GRANULES && header_tag[g][CLASS_W] &&
                header_tag[g][CLASS_W-1:0] < N_CLASSES) begin
               c = 32'(header_tag[g][CLASS_W-1:0]);
               header_tag[g] = '0;
               push_free(c, g);
               r.address    = user_addr;
               r.size_class = CLASS_W'(c);
               r.status     = STATUS_OK;
            end
         end
      end else begin
         need = nbytes + HDR_BYTES;
         c = 0;
         while (c < N_CLASSES && class_size(c) < need) c++;
         if (c >= N_CLASSES) begin
            r.status = STATUS_TOO_LARGE;
         end else if (head_ok[c]) begin
            g = pop_free(c);
            header_tag[g] = {1'b1, c[CLASS_W-1:0]};
            r.address    = ADDR_W'((g << 4) + HDR_BYTES);
            r.size_class = CLASS_W'(c);
         end else begin
            fresh = open_blocks == 0 || bump + class_size(c) > BLK_BYTES;
            if (fresh && open_blocks >= N_BLOCKS) begin
               r.status = STATUS_EXHAUSTED;
            end else begin
               if (fresh) begin
                  if (open_blocks != 0) carve_rest();
                  open_blocks++;
                  bump = 0;
               end
               start = (open_blocks - 1) * BLK_BYTES + bump;
               bump += class_size(c);
               header_tag[start >> 4] = {1'b1, c[CLASS_W-1:0]};
               r.address    = ADDR_W'(start + HDR_BYTES);
               r.size_class = CLASS_W'(c);
            end
         end
      end
      r.blocks = BLOCKS_W'(open_blocks);
      return r;
   endfunction

   always @(posedge clock) begin
      alloc_result_type got, want;
      if (reset) begin
         for (int c = 0; c < N_CLASSES; c++) begin
            head_ok[c]   = 1'b0;
            head_gran[c] = '0;
         end
         for (int g = 0; g < N_GRANULES; g++) header_tag[g] = '0;
         bump        = 0;
         open_blocks = 0;
         errors      = 0;
         expected_results.delete();
      end else begin
         if (req_tvalid && req_tready)
            expected_results.push_back(predict_alloc(req_tuser, req_tdata[15:0],
                                                     req_tdata[37:17]));
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (expected_results.size() == 0) begin
               errors++;
               $display("%0t: unexpected word, actual %h", $realtime, got);
            end else begin
               want = expected_results.pop_front();
               if (got.address !== want.address) begin
                  errors++;
                  $display("%0t: address expected %h actual %h", $realtime,
                           want.address, got.address);
               end
               if (got.size_class !== want.size_class) begin
                  errors++;
                  $display("%0t: size_class expected %0d actual %0d", $realtime,
                           want.size_class, got.size_class);
               end
               if (got.status !== want.status) begin
                  errors++;
                  $display("%0t: status expected %0d actual %0d", $realtime,
                           want.status, got.status);
               end
               if (got.blocks !== want.blocks) begin
                  errors++;
                  $display("%0t: blocks_in_use expected %0d actual %0d", $realtime,
                           want.blocks, got.blocks);
               end
            end
         end
      end
   end

endmodule

/* tb/sv/testbench.sv */
module testbench import scpa_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 1000000;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic                   req_tuser = REQ_ALLOC;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   int                     errors, pending;
   int                     cycles = 0;
   int                     send_idle = 19;
   int                     recv_idle = 49;
   logic                   sent_kinds [$];
   logic [20:0]            live_addrs [$];
   logic [20:0]            freed_addrs [$];

   size_class_pool_allocator_core i_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   pool_alloc_checker i_checker (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .errors(errors), .pending(pending)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   always @(posedge clock) rsp_tready <= $urandom_range(99) >= recv_idle;

   // Track addresses handed out so that most frees name a live piece.
   always @(posedge clock) begin
      logic kind;
      if (!reset && rsp_tvalid && rsp_tready && sent_kinds.size() != 0) begin
         kind = sent_kinds.pop_front();
         if (kind == REQ_ALLOC && rsp_tdata[26:25] == STATUS_OK)
            live_addrs.push_back(rsp_tdata[20:0]);
      end
   end

   task automatic send_word(logic kind, logic [15:0] nbytes, logic stats,
                            logic [20:0] user_addr);
      logic ok;
      while ($urandom_range(99) < send_idle) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {2'b00, user_addr, stats, nbytes};
      forever begin
         @(negedge clock);
         ok = req_tready;
         @(posedge clock);
         if (ok) break;
      end
      sent_kinds.push_back(kind);
   endtask

   task automatic free_word(logic [20:0] user_addr);
      send_word(REQ_FREE, 16'($urandom), 1'($urandom), user_addr);
   endtask

   task automatic alloc_word(logic [15:0] nbytes);
      send_word(REQ_ALLOC, nbytes, 1'($urandom), 21'($urandom));
   endtask

   initial begin
      int          pick, idx;
      logic [15:0] nbytes;
      logic [20:0] a;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Class boundaries, oversize requests and the bad-mark cases.
      send_word(REQ_ALLOC, 16'd0, 1'b1, 21'd0);
      send_word(REQ_ALLOC, 16'd14, 1'b0, 21'h1FFFFF);
      alloc_word(16'd15);
      alloc_word(16'd32766);
      alloc_word(16'd32767);
      alloc_word(16'hFFFF);
      free_word(21'd2);
      free_word(21'd2);
      free_word(21'd0);
      free_word(21'd1);
      free_word(21'd3);
      free_word(21'h1FFFFF);
      free_word(21'd34);
      alloc_word(16'd0);
      alloc_word(16'd30);
      alloc_word(16'd1000);
      alloc_word(16'd8190);
      free_word(21'h0AAAAA);
      free_word(21'h155552);

      for (int i = 0; i < 680; i++) begin
         if (i == 230) begin
            send_idle = 49;
            recv_idle = 19;
         end else if (i == 460) begin
            send_idle = 0;
            recv_idle = 0;
         end
         pick = $urandom_range(99);
         if (i >= 560) begin
            // Large pieces only, to run the pool out of blocks.
            alloc_word(16'($urandom_range(16382, 32766)));
         end else if (pick < 55) begin
            pick = $urandom_range(99);
            if (pick < 50) nbytes = 16'($urandom_range(0, 200));
            else if (pick < 80) nbytes = 16'($urandom_range(0, 4094));
            else if (pick < 94) nbytes = 16'($urandom_range(4095, 32766));
            else nbytes = 16'($urandom_range(32767, 65535));
            alloc_word(nbytes);
         end else if (pick < 88 && live_addrs.size() != 0) begin
            idx = $urandom_range(live_addrs.size() - 1);
            a = live_addrs[idx];
            live_addrs.delete(idx);
            freed_addrs.push_back(a);
            free_word(a);
         end else if (pick < 94 && freed_addrs.size() != 0) begin
            free_word(freed_addrs[$urandom_range(freed_addrs.size() - 1)]);
         end else if (pick < 97) begin
            free_word(21'(($urandom_range(0, 131071) << 4) + 2));
         end else begin
            free_word(21'($urandom));
         end
      end
      req_tvalid <= 1'b0;

      while (pending != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (errors == 0) $display("status: pass");
      else $display("status: fail");
      $finish;
   end

endmodule
